// File: hdl/particle_swarm_update_defines.svh
// Assertion macros for the particle swarm update engine.
`ifndef PARTICLE_SWARM_UPDATE_DEFINES_SVH
`define PARTICLE_SWARM_UPDATE_DEFINES_SVH
`ifndef SYNTHESIS
`define PSU_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PSU_ASSERT_IMPL(label, clk, rst, ante, cons)
`define PSU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hdl/psu_pkg.sv
`default_nettype none
package psu_pkg;

  // Swarm size; the request fields are sized for these.
  localparam int PARTICLES = 64;
  localparam int DIMS      = 32;

  // Command codes.
  localparam logic [2:0] CMD_LOAD   = 3'd0;
  localparam logic [2:0] CMD_UPDATE = 3'd1;
  localparam logic [2:0] CMD_REPORT = 3'd2;
  localparam logic [2:0] CMD_INIT   = 3'd3;
  localparam logic [2:0] CMD_READ   = 3'd4;

  // Register indexes.
  localparam logic [2:0] REG_INERTIA  = 3'd0;
  localparam logic [2:0] REG_COG      = 3'd1;
  localparam logic [2:0] REG_SOC      = 3'd2;
  localparam logic [2:0] REG_POS_LIM  = 3'd3;
  localparam logic [2:0] REG_VEL_LIM  = 3'd4;
  localparam logic [2:0] REG_MAXIMIZE = 3'd5;

  typedef struct packed {
    logic [2:0]         command;
    logic [5:0]         particle;
    logic [4:0]         dimension;
    logic signed [31:0] position_in;
    logic signed [31:0] velocity_in;
    logic [9:0]         rand_cognitive;
    logic [9:0]         rand_social;
    logic signed [31:0] fitness;
  } request_t;

  typedef struct packed {
    logic signed [31:0] position_out;
    logic signed [31:0] velocity_out;
    logic               personal_improved;
    logic               global_improved;
    logic signed [31:0] best_fitness;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,      // memory read issued
    ST_LOAD,    // load write
    ST_MUL0,    // inertia product
    ST_MUL1,    // cognitive gain * r1
    ST_MUL2,    // cognitive product
    ST_MUL3,    // social gain * r2
    ST_MUL4,    // social product
    ST_CLAMP,   // clamp velocity and position, write back
    ST_COPY_RD, // copy loop read
    ST_COPY_WR, // copy loop write
    ST_DONE     // result waits
  } state_t;

  // Round to nearest, ties up, then shift right.
  function automatic logic signed [65:0] shr_round(input logic signed [65:0] x,
                                                   input logic [4:0] k);
    logic signed [65:0] y;
    y = x + (66'sd1 <<< (k - 5'd1));
    return y >>> k;
  endfunction

endpackage
`default_nettype wire

// File: hdl/psu_ram.sv
`default_nettype none
module psu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hdl/particle_swarm_update.sv
// Particle swarm update engine (inertia weight form, Q16.16 fixed point).
// Requests arrive on in_valid/in_stall carrying psu_pkg::request_t; one
// result per request leaves on out_valid/out_stall as psu_pkg::result_t.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle; the user must
// keep to this, as the block does not enforce it. One request is worked on at a time;
// in_stall is high from the edge that accepts a request until its result has been taken.
// A read, a report that improves nothing, initial fitness of a particle other
// than 0 and unknown or out-of-range requests go from decode straight to the
// result; a load adds its write; an update steps through one shared signed
// multiplier used five times in turn; a report that wins and initial fitness
// of particle 0 run the vector copy through the memory ports.
// The result register holds its value while out_stall is high. The next
// request is taken no earlier than the cycle after the result is gone, so a
// new request waits for the last result and for any output stall.
// Reset clears configuration to defaults, the global best fitness and the
// control state; vector memories and personal best fitness values are left
// undefined until written.
`default_nettype none
`include "particle_swarm_update_defines.svh"
module particle_swarm_update (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire psu_pkg::request_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output psu_pkg::result_t       out_data,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [30:0]       cfg_data
);

  localparam int PARTICLES = psu_pkg::PARTICLES;
  localparam int DIMS = psu_pkg::DIMS;
  localparam int PW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
  localparam int DW = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int EW = PW + DW;
  localparam int EDEPTH = 1 << EW;

  // Configuration registers.
  logic [15:0] inertia_weight, cognitive_gain, social_gain;
  logic [30:0] position_limit, velocity_limit;
  logic        maximize;

  always_ff @(posedge clk) begin
    if (rst) begin
      inertia_weight <= 16'd11469;
      cognitive_gain <= 16'd8192;
      social_gain    <= 16'd8192;
      position_limit <= 31'd6553600;
      velocity_limit <= 31'd32768;
      maximize       <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        psu_pkg::REG_INERTIA:  inertia_weight <= cfg_data[15:0];
        psu_pkg::REG_COG:      cognitive_gain <= cfg_data[15:0];
        psu_pkg::REG_SOC:      social_gain    <= cfg_data[15:0];
        psu_pkg::REG_POS_LIM:  position_limit <= cfg_data;
        psu_pkg::REG_VEL_LIM:  velocity_limit <= cfg_data;
        psu_pkg::REG_MAXIMIZE: maximize       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  psu_pkg::state_t state, state_next;
  psu_pkg::request_t req;
  logic [PW-1:0] preq;
  logic [DW-1:0] dreq;
  logic [DW:0]   cnt;          // copy counter
  logic          copy_pb, copy_gb;
  logic signed [31:0] gbest_fit;
  logic signed [65:0] acc;     // sum of rounded terms
  logic signed [32:0] diff;
  logic [25:0] gr;             // gain * r
  logic signed [31:0] xold;
  logic signed [31:0] nv, nx;
  psu_pkg::result_t res, res_rd;

  // Shared multiplier: operands chosen per step.
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;
  logic signed [65:0] mul_r;

  logic p_ok, d_ok;
  assign p_ok = ({26'd0, req.particle} < 32'(PARTICLES));
  assign d_ok = ({27'd0, req.dimension} < 32'(DIMS));

  // Memory ports.
  logic          pos_we, vel_we, pbp_we, gbp_we, pbf_we;
  logic [EW-1:0] pos_wa, pos_ra, pbp_wa, vel_a;
  logic [31:0]   pos_wd, vel_wd, pbp_wd, gbp_wd;
  logic [31:0]   pos_rd, vel_rd, pbp_rd, gbp_rd, pbf_rd;
  logic [DW-1:0] gbp_wa, gbp_ra;
  logic [PW-1:0] pbf_ra;

  psu_ram #(.WIDTH(32), .DEPTH(EDEPTH)) u_pos (
    .clk, .we(pos_we), .waddr(pos_wa), .wdata(pos_wd), .raddr(pos_ra), .rdata(pos_rd));
  psu_ram #(.WIDTH(32), .DEPTH(EDEPTH)) u_vel (
    .clk, .we(vel_we), .waddr(vel_a), .wdata(vel_wd), .raddr(vel_a), .rdata(vel_rd));
  psu_ram #(.WIDTH(32), .DEPTH(EDEPTH)) u_pbp (
    .clk, .we(pbp_we), .waddr(pbp_wa), .wdata(pbp_wd), .raddr(pos_ra), .rdata(pbp_rd));
  psu_ram #(.WIDTH(32), .DEPTH(1 << DW)) u_gbp (
    .clk, .we(gbp_we), .waddr(gbp_wa), .wdata(gbp_wd), .raddr(gbp_ra), .rdata(gbp_rd));
  psu_ram #(.WIDTH(32), .DEPTH(1 << PW)) u_pbf (
    .clk, .we(pbf_we), .waddr(preq), .wdata(req.fitness), .raddr(pbf_ra), .rdata(pbf_rd));

  logic [DW-1:0] cnt_d;
  assign cnt_d = cnt[DW-1:0];

  // Address and write selection.
  always_comb begin
    pos_ra = (state == psu_pkg::ST_IDLE) ? {in_data.particle[PW-1:0], in_data.dimension[DW-1:0]}
           : (state == psu_pkg::ST_COPY_RD || state == psu_pkg::ST_COPY_WR)
             ? {preq, cnt_d} : {preq, dreq};
    vel_a  = (state == psu_pkg::ST_IDLE) ? {in_data.particle[PW-1:0], in_data.dimension[DW-1:0]}
           : {preq, dreq};
    gbp_ra = (state == psu_pkg::ST_IDLE) ? in_data.dimension[DW-1:0] : dreq;
    pbf_ra = (state == psu_pkg::ST_IDLE) ? in_data.particle[PW-1:0] : preq;
    pos_wa = {preq, dreq};
    pos_we = 1'b0; vel_we = 1'b0; pbp_we = 1'b0; gbp_we = 1'b0;
    pos_wd = req.position_in; vel_wd = req.velocity_in;
    pbp_wa = {preq, dreq}; pbp_wd = req.position_in;
    gbp_wa = cnt_d; gbp_wd = pos_rd;
    if (state == psu_pkg::ST_LOAD) begin
      pos_we = 1'b1; vel_we = 1'b1; pbp_we = 1'b1;
    end else if (state == psu_pkg::ST_CLAMP) begin
      pos_we = 1'b1; vel_we = 1'b1;
      pos_wd = nx; vel_wd = nv;
    end else if (state == psu_pkg::ST_COPY_WR) begin
      pbp_we = copy_pb; gbp_we = copy_gb;
      pbp_wa = {preq, cnt_d}; pbp_wd = pos_rd;
    end
  end

  // Multiplier operand select.
  always_comb begin
    mul_a = '0; mul_b = '0;
    unique case (state)
      psu_pkg::ST_MUL0: begin mul_a = 34'(inertia_weight); mul_b = 34'(signed'(vel_rd)); end
      psu_pkg::ST_MUL1: begin mul_a = 34'(cognitive_gain); mul_b = 34'(req.rand_cognitive); end
      psu_pkg::ST_MUL3: begin mul_a = 34'(social_gain); mul_b = 34'(req.rand_social); end
      psu_pkg::ST_MUL2, psu_pkg::ST_MUL4: begin mul_a = 34'(gr); mul_b = 34'(diff); end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
    mul_r = mul_p[65:0];
  end

  // Clamp stage.
  logic signed [65:0] vl, pl, xs;
  always_comb begin
    vl = 66'(velocity_limit);
    pl = 66'(position_limit);
    if (acc > vl) nv = 32'(velocity_limit);
    else if (acc < -vl) nv = -32'(velocity_limit);
    else nv = acc[31:0];
    xs = 66'(xold) + 66'(nv);
    if (xs > pl) nx = 32'(position_limit);
    else if (xs < -pl) nx = -32'(position_limit);
    else nx = xs[31:0];
  end

  logic better_p, better_g;
  logic signed [31:0] pb_cur;
  assign pb_cur = signed'(pbf_rd);
  assign better_p = maximize ? (req.fitness > pb_cur) : (req.fitness < pb_cur);
  assign better_g = maximize ? (req.fitness > gbest_fit) : (req.fitness < gbest_fit);

  // Personal best fitness is written once the request has been decoded.
  assign pbf_we = (state == psu_pkg::ST_RD) && p_ok &&
                  ((req.command == psu_pkg::CMD_INIT) ||
                   (req.command == psu_pkg::CMD_REPORT && better_p));

  // Result fields known right after decode.
  always_comb begin
    res_rd = '0;
    if (p_ok && req.command == psu_pkg::CMD_REPORT) begin
      res_rd.personal_improved = better_p;
      res_rd.global_improved   = better_g;
    end
    if (req.command == psu_pkg::CMD_READ && d_ok) res_rd.position_out = gbp_rd;
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      psu_pkg::ST_IDLE: if (in_valid) state_next = psu_pkg::ST_RD;
      psu_pkg::ST_RD: begin
        if (req.command == psu_pkg::CMD_LOAD && p_ok && d_ok) state_next = psu_pkg::ST_LOAD;
        else if (req.command == psu_pkg::CMD_UPDATE && p_ok && d_ok)
          state_next = psu_pkg::ST_MUL0;
        else if (req.command == psu_pkg::CMD_REPORT && p_ok && (better_p || better_g))
          state_next = psu_pkg::ST_COPY_RD;
        else if (req.command == psu_pkg::CMD_INIT && p_ok && req.particle == 6'd0)
          state_next = psu_pkg::ST_COPY_RD;
        else state_next = psu_pkg::ST_DONE;
      end
      psu_pkg::ST_LOAD:  state_next = psu_pkg::ST_DONE;
      psu_pkg::ST_MUL0:  state_next = psu_pkg::ST_MUL1;
      psu_pkg::ST_MUL1:  state_next = psu_pkg::ST_MUL2;
      psu_pkg::ST_MUL2:  state_next = psu_pkg::ST_MUL3;
      psu_pkg::ST_MUL3:  state_next = psu_pkg::ST_MUL4;
      psu_pkg::ST_MUL4:  state_next = psu_pkg::ST_CLAMP;
      psu_pkg::ST_CLAMP: state_next = psu_pkg::ST_DONE;
      psu_pkg::ST_COPY_RD: state_next = psu_pkg::ST_COPY_WR;
      psu_pkg::ST_COPY_WR:
        state_next = (cnt == (DW+1)'(DIMS - 1)) ? psu_pkg::ST_DONE : psu_pkg::ST_COPY_RD;
      psu_pkg::ST_DONE: if (!out_stall) state_next = psu_pkg::ST_IDLE;
      default: state_next = psu_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_stall  = (state != psu_pkg::ST_IDLE);
    out_valid = (state == psu_pkg::ST_DONE);
    out_data  = res;
    out_data.best_fitness = gbest_fit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= psu_pkg::ST_IDLE;
      gbest_fit <= '0;
    end else begin
      state <= state_next;
      if (state == psu_pkg::ST_RD && p_ok) begin
        if (req.command == psu_pkg::CMD_INIT) begin
          if (req.particle == 6'd0) gbest_fit <= req.fitness;
        end else if (req.command == psu_pkg::CMD_REPORT && better_g) begin
          gbest_fit <= req.fitness;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      psu_pkg::ST_IDLE: begin
        req  <= in_data;
        preq <= in_data.particle[PW-1:0];
        dreq <= in_data.dimension[DW-1:0];
        cnt  <= '0;
      end
      psu_pkg::ST_RD: begin
        res <= res_rd;
        xold <= pos_rd;
        diff <= 33'(signed'(pbp_rd)) - 33'(signed'(pos_rd));
        copy_pb <= (req.command == psu_pkg::CMD_REPORT) && better_p;
        copy_gb <= (req.command == psu_pkg::CMD_REPORT) ? better_g : 1'b1;
      end
      psu_pkg::ST_LOAD: begin
        res.position_out <= req.position_in;
        res.velocity_out <= req.velocity_in;
      end
      psu_pkg::ST_MUL0: acc <= psu_pkg::shr_round(mul_r, 5'd14);
      psu_pkg::ST_MUL1: gr <= mul_r[25:0];
      psu_pkg::ST_MUL2: begin
        acc  <= acc + psu_pkg::shr_round(mul_r, 5'd22);
        diff <= 33'(signed'(gbp_rd)) - 33'(xold);
      end
      psu_pkg::ST_MUL3: gr <= mul_r[25:0];
      psu_pkg::ST_MUL4: acc <= acc + psu_pkg::shr_round(mul_r, 5'd22);
      psu_pkg::ST_CLAMP: begin
        res.position_out <= nx;
        res.velocity_out <= nv;
      end
      psu_pkg::ST_COPY_WR: cnt <= cnt + 1'b1;
      default: ;
    endcase
  end

  `PSU_ASSERT_IMPL(a_busy_stall, clk, rst, state != psu_pkg::ST_IDLE, in_stall)
  `PSU_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  `PSU_ASSERT_IMPL(a_cnt_range, clk, rst, state == psu_pkg::ST_COPY_WR,
    cnt < (DW+1)'(DIMS))

endmodule
`default_nettype wire

// File: dv/particle_swarm_update_test.sv
`default_nettype none
module particle_swarm_update_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PARTICLES = 64;
  localparam int DIMS = 32;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS = 110;

  // Tracks swarm state and the result expected for every accepted request.
  class swarm_scoreboard;
    longint inertia, cog_gain, soc_gain, pos_limit, vel_limit;
    bit maximize_mode;
    int pos_mem[PARTICLES*DIMS];
    int vel_mem[PARTICLES*DIMS];
    int pbest_pos[PARTICLES*DIMS];
    int pbest_fit[PARTICLES];
    int cur_fit[PARTICLES];
    int gbest_pos[DIMS];
    int gbest_fit;
    psu_pkg::result_t pending[$];
    int errors;

    function new();
      inertia = 11469;
      cog_gain = 8192;
      soc_gain = 8192;
      pos_limit = 6553600;
      vel_limit = 32768;
      maximize_mode = 0;
      gbest_fit = 0;
      errors = 0;
      foreach (cur_fit[i]) cur_fit[i] = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [30:0] val);
      case (idx)
        psu_pkg::REG_INERTIA: inertia = longint'(val[15:0]);
        psu_pkg::REG_COG: cog_gain = longint'(val[15:0]);
        psu_pkg::REG_SOC: soc_gain = longint'(val[15:0]);
        psu_pkg::REG_POS_LIM: pos_limit = longint'(val);
        psu_pkg::REG_VEL_LIM: vel_limit = longint'(val);
        psu_pkg::REG_MAXIMIZE: maximize_mode = val[0];
        default: ;
      endcase
    endfunction

    function bit beats(int a, int b);
      return maximize_mode ? (a > b) : (a < b);
    endfunction

    // Rounds to nearest with ties upward, then shifts.
    function longint round_shift(longint x, int k);
      return (x + (64'sd1 <<< (k - 1))) >>> k;
    endfunction

    function longint clamp(longint x, longint lim);
      if (x > lim) return lim;
      if (x < -lim) return -lim;
      return x;
    endfunction

    // Applies one request to the swarm state and queues its result.
    function void note_request(psu_pkg::request_t q);
      psu_pkg::result_t r;
      int p, d, e, base;
      longint x, v, t0, t1, t2, nv, nx;
      p = int'(q.particle);
      d = int'(q.dimension);
      base = p * DIMS;
      e = base + d;
      r = '0;
      case (q.command)
        psu_pkg::CMD_LOAD: begin
          pos_mem[e] = q.position_in;
          vel_mem[e] = q.velocity_in;
          pbest_pos[e] = q.position_in;
          r.position_out = q.position_in;
          r.velocity_out = q.velocity_in;
        end
        psu_pkg::CMD_UPDATE: begin
          x = pos_mem[e];
          v = vel_mem[e];
          t0 = round_shift(inertia * v, 14);
          t1 = round_shift(cog_gain * longint'(q.rand_cognitive) * (pbest_pos[e] - x), 22);
          t2 = round_shift(soc_gain * longint'(q.rand_social) * (gbest_pos[d] - x), 22);
          nv = clamp(t0 + t1 + t2, vel_limit);
          nx = clamp(x + nv, pos_limit);
          vel_mem[e] = int'(nv);
          pos_mem[e] = int'(nx);
          r.position_out = int'(nx);
          r.velocity_out = int'(nv);
        end
        psu_pkg::CMD_REPORT: begin
          cur_fit[p] = q.fitness;
          if (beats(q.fitness, pbest_fit[p])) begin
            pbest_fit[p] = q.fitness;
            for (int i = 0; i < DIMS; i++) pbest_pos[base + i] = pos_mem[base + i];
            r.personal_improved = 1'b1;
          end
          if (beats(q.fitness, gbest_fit)) begin
            gbest_fit = q.fitness;
            for (int i = 0; i < DIMS; i++) gbest_pos[i] = pos_mem[base + i];
            r.global_improved = 1'b1;
          end
        end
        psu_pkg::CMD_INIT: begin
          pbest_fit[p] = q.fitness;
          cur_fit[p] = q.fitness;
          if (p == 0) begin
            gbest_fit = q.fitness;
            for (int i = 0; i < DIMS; i++) gbest_pos[i] = pos_mem[i];
          end
        end
        psu_pkg::CMD_READ: r.position_out = gbest_pos[d];
        default: ;
      endcase
      r.best_fitness = gbest_fit;
      pending.push_back(r);
    endfunction

    task report(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch on %s: got %h, expected %h at %0t", field, got, want, $realtime);
      errors++;
    endtask

    task check_result(psu_pkg::result_t r);
      psu_pkg::result_t want;
      if (pending.size() == 0) begin
        report("unexpected result", r.position_out, '0);
        return;
      end
      want = pending.pop_front();
      if (r.position_out !== want.position_out)
        report("position_out", r.position_out, want.position_out);
      if (r.velocity_out !== want.velocity_out)
        report("velocity_out", r.velocity_out, want.velocity_out);
      if (r.personal_improved !== want.personal_improved)
        report("personal_improved", 32'(r.personal_improved), 32'(want.personal_improved));
      if (r.global_improved !== want.global_improved)
        report("global_improved", 32'(r.global_improved), 32'(want.global_improved));
      if (r.best_fitness !== want.best_fitness)
        report("best_fitness", r.best_fitness, want.best_fitness);
    endtask
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  psu_pkg::request_t in_data;
  logic out_valid;
  logic out_stall;
  psu_pkg::result_t out_data;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [30:0] cfg_data;

  swarm_scoreboard swarm = new();

  // Which elements hold defined data, so no undefined entry is ever read.
  bit loaded[PARTICLES*DIMS];
  int loaded_count[PARTICLES];
  bit pbest_fit_set[PARTICLES];
  bit gbest_set;
  int hot_particle;
  bit send_burst;
  bit recv_burst;
  int idle_cycles;

  particle_swarm_update u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Ends the run when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stall before each result, with stretches of none.
  initial begin
    int gap;
    out_stall = 1'b0;
    recv_burst = 1'b0;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 31) == 0) recv_burst = ~recv_burst;
      gap = recv_burst ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      swarm.check_result(out_data);
    end
  end

  function automatic psu_pkg::request_t random_request();
    psu_pkg::request_t q;
    q.command = 3'($urandom_range(0, 7));
    q.particle = 6'($urandom_range(0, PARTICLES - 1));
    q.dimension = 5'($urandom_range(0, DIMS - 1));
    q.position_in = $urandom;
    q.velocity_in = $urandom;
    q.rand_cognitive = 10'($urandom_range(0, 1023));
    q.rand_social = 10'($urandom_range(0, 1023));
    q.fitness = $urandom;
    return q;
  endfunction

  function automatic int first_unloaded(int p);
    for (int i = 0; i < DIMS; i++)
      if (!loaded[p * DIMS + i]) return i;
    return 0;
  endfunction

  // Rewrites a request that would read undefined data into a load that fills the
  // particle's vector, or a report without personal best fitness into an init.
  function automatic psu_pkg::request_t make_legal(psu_pkg::request_t q);
    int p, e;
    bit need_load;
    p = int'(q.particle);
    e = p * DIMS + int'(q.dimension);
    need_load = 1'b0;
    case (q.command)
      psu_pkg::CMD_UPDATE: need_load = !loaded[e] || !gbest_set;
      psu_pkg::CMD_REPORT: begin
        if (loaded_count[p] < DIMS) need_load = 1'b1;
        else if (!pbest_fit_set[p]) q.command = psu_pkg::CMD_INIT;
      end
      psu_pkg::CMD_INIT: need_load = (p == 0) && (loaded_count[0] < DIMS);
      psu_pkg::CMD_READ: need_load = !gbest_set;
      default: ;
    endcase
    if (need_load) begin
      q.command = psu_pkg::CMD_LOAD;
      if (loaded_count[p] < DIMS) q.dimension = 5'(first_unloaded(p));
    end
    return q;
  endfunction

  // Sends one request, noting it at the edge where it is taken.
  task send_request(psu_pkg::request_t q);
    int gap, e;
    if ($urandom_range(0, 31) == 0) send_burst = ~send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= q;
    do @(posedge clk); while (in_stall);
    swarm.note_request(q);
    e = int'(q.particle) * DIMS + int'(q.dimension);
    case (q.command)
      psu_pkg::CMD_LOAD: begin
        if (!loaded[e]) loaded_count[q.particle]++;
        loaded[e] = 1'b1;
      end
      psu_pkg::CMD_INIT: begin
        pbest_fit_set[q.particle] = 1'b1;
        if (q.particle == 6'd0) gbest_set = 1'b1;
      end
      psu_pkg::CMD_REPORT: if (swarm.pending[$].global_improved) gbest_set = 1'b1;
      default: ;
    endcase
  endtask

  // Holds off until every result is back and the block is idle again.
  task drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (swarm.pending.size() != 0 || in_stall);
  endtask

  // Writes one register; the caller drops the write enable after the last one.
  task write_reg(logic [2:0] idx, logic [30:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    swarm.set_reg(idx, val);
  endtask

  task configure(logic [15:0] w, logic [15:0] c1, logic [15:0] c2,
                 logic [30:0] plim, logic [30:0] vlim, logic maxim);
    write_reg(psu_pkg::REG_INERTIA, 31'(w));
    write_reg(psu_pkg::REG_COG, 31'(c1));
    write_reg(psu_pkg::REG_SOC, 31'(c2));
    write_reg(psu_pkg::REG_POS_LIM, plim);
    write_reg(psu_pkg::REG_VEL_LIM, vlim);
    write_reg(psu_pkg::REG_MAXIMIZE, 31'(maxim));
    cfg_we <= 1'b0;
  endtask

  // Random request mostly aimed at a few particles so vectors fill up.
  function automatic psu_pkg::request_t swarm_request();
    psu_pkg::request_t q;
    int pick;
    q = random_request();
    pick = $urandom_range(0, 99);
    if (pick < 30) q.command = psu_pkg::CMD_LOAD;
    else if (pick < 62) q.command = psu_pkg::CMD_UPDATE;
    else if (pick < 78) q.command = psu_pkg::CMD_REPORT;
    else if (pick < 85) q.command = psu_pkg::CMD_INIT;
    else if (pick < 94) q.command = psu_pkg::CMD_READ;
    else q.command = 3'($urandom_range(psu_pkg::CMD_READ + 1, 7));
    case ($urandom_range(0, 9))
      0, 1, 2: q.particle = '0;
      3, 4: q.particle = 6'(PARTICLES - 1);
      5, 6, 7: q.particle = 6'(hot_particle);
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0) q.position_in = $signed(q.position_in) >>> 12;
    return make_legal(q);
  endfunction

  initial begin
    psu_pkg::request_t q;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = psu_pkg::REG_INERTIA;
    cfg_data = '0;
    send_burst = 1'b0;
    gbest_set = 1'b0;
    hot_particle = $urandom_range(1, PARTICLES - 2);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extreme loads, initial fitness off particle 0, bad commands.
    for (int i = 0; i < 4; i++) begin
      q = random_request();
      q.command = psu_pkg::CMD_LOAD;
      q.particle = (i < 2) ? 6'(PARTICLES - 1) : 6'd0;
      q.dimension = (i % 2) ? 5'(DIMS - 1) : 5'd0;
      q.position_in = (i % 2) ? 32'sh7fffffff : 32'sh80000000;
      q.velocity_in = (i % 2) ? 32'sh80000000 : 32'sh7fffffff;
      send_request(q);
    end
    for (int i = 0; i < 2; i++) begin
      q = random_request();
      q.command = psu_pkg::CMD_INIT;
      q.particle = 6'(PARTICLES - 1);
      q.fitness = i ? 32'sh80000000 : 32'sh7fffffff;
      send_request(q);
    end
    for (int c = psu_pkg::CMD_READ + 1; c <= 7; c++) begin
      q = random_request();
      q.command = 3'(c);
      send_request(q);
    end

    // Random phases, each under its own register setting.
    for (int phase = 0; phase < 4; phase++) begin
      drain();
      case (phase)
        0: configure(16'd11469, 16'd8192, 16'd8192, 31'd6553600, 31'd32768, 1'b0);
        1: configure(16'hffff, 16'hffff, 16'hffff, 31'h7fffffff, 31'h7fffffff, 1'b1);
        2: configure(16'h0000, 16'h0000, 16'h0000, 31'h0, 31'h0, 1'b0);
        default: configure(16'($urandom), 16'($urandom), 16'($urandom),
                           31'($urandom_range(0, 32'h7fffffff)),
                           31'($urandom_range(0, 32'h7fffff)), 1'($urandom_range(0, 1)));
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 1 && n == PHASE_ITEMS / 2) drain();
        send_request(swarm_request());
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (swarm.pending.size() != 0);
    repeat (20) @(posedge clk);
    if (swarm.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
